FILE: design/gcms_pkg.sv
// ----------------------------------------------------------------------------
// Gated CV merge selector package
// Shared types, register codes, rule codes and the reciprocal table used by
// the divide-by-count path.
// ----------------------------------------------------------------------------
package gcms_pkg;

	localparam int MAX_PORTS   = 8;
	localparam int LANE_W      = 16;
	localparam int CV_W        = 19;
	localparam int CHOICE_W    = 4;
	localparam int RULE_W      = 3;
	localparam int ADDR_W      = 4;
	localparam int DATA_W      = 32;
	localparam int RECIP_W     = 23;
	localparam int RECIP_SHIFT = 22;
	localparam int RECIP_IDX_W = 4;
	localparam int PROD_W      = CV_W + RECIP_W;

	typedef logic [RULE_W-1:0]   rule_t;
	typedef logic [CHOICE_W-1:0] choice_t;

	localparam rule_t RULE_FIRST = 3'd0;
	localparam rule_t RULE_LAST  = 3'd1;
	localparam rule_t RULE_MIN   = 3'd2;
	localparam rule_t RULE_MAX   = 3'd3;
	localparam rule_t RULE_AVG   = 3'd4;
	localparam rule_t RULE_SUM   = 3'd5;
	localparam rule_t RULE_PREV  = 3'd6;

	// Choice codes below CHOICE_AVG name a port.
	localparam choice_t CHOICE_AVG = 4'd8;
	localparam choice_t CHOICE_SUM = 4'd9;

	localparam logic signed [LANE_W-1:0] TRIG_LOW_RST  = 16'sd205;
	localparam logic signed [LANE_W-1:0] TRIG_HIGH_RST = 16'sd2048;

	typedef enum logic [1:0] {
		REG_HOLD_MODE,
		REG_PICK_RULE,
		REG_TRIG_LOW,
		REG_TRIG_HIGH
	} reg_idx_t;

	typedef struct packed {
		logic                     hold_mode;
		rule_t                    pick_rule;
		logic signed [LANE_W-1:0] trigger_low;
		logic signed [LANE_W-1:0] trigger_high;
	} cfg_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EVAL,
		ST_SELECT,
		ST_DIV_MUL,
		ST_DIV_FIN,
		ST_FINISH
	} state_t;

	typedef struct packed {
		logic load_in;
		logic eval;
		logic select;
		logic div_mul;
		logic div_fin;
		logic out_load;
	} cmd_t;

	typedef struct packed {
		logic bypass;
		logic do_pick;
		logic need_div;
		logic out_free;
	} status_t;

	// ceil(2^22 / c) for c = 1..8; entry 0 makes a zero count give zero.
	localparam logic [RECIP_W-1:0] RECIP_TABLE [0:MAX_PORTS] = '{
		23'd0,
		23'd4194304,
		23'd2097152,
		23'd1398102,
		23'd1048576,
		23'd838861,
		23'd699051,
		23'd599187,
		23'd524288
	};

endpackage

FILE: design/gated_cv_merge_selector.sv
// ----------------------------------------------------------------------------
// Gated CV merge selector
// Hysteresis-clocked gate sampling with a selectable merge of gated CVs.
// ----------------------------------------------------------------------------
// Sequence: a beat is captured on accept, then evaluated; a bypass or a tick
// without update goes straight to the output load, an update passes through
// select, and the average adds the reciprocal multiply and scale steps.
// The block takes no new beat until the output load of the last one is done.
// Reset: arst_n clears all triggers, the held CV, the choice and the output valid flag.
// The result register lets the next beat be accepted while a result waits.
module gated_cv_merge_selector #(
	parameter int PORTS     = 8,
	parameter int VOLT_BITS = 16
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	// Configuration port. Registers sit at byte addresses 0, 4, 8 and 12.
	input  logic                                 psel,
	input  logic                                 penable,
	input  logic                                 pwrite,
	input  logic [gcms_pkg::ADDR_W-1:0]          paddr,
	input  logic [gcms_pkg::DATA_W-1:0]          pwdata,
	output logic [gcms_pkg::DATA_W-1:0]          prdata,
	output logic                                 pready,
	// Input channel.
	input  logic                                 in_valid,
	output logic                                 in_ready,
	input  logic                                 action,
	input  logic signed [gcms_pkg::LANE_W-1:0]   clock_level,
	input  logic                                 clock_present,
	input  logic [4*gcms_pkg::LANE_W-1:0]        gate_levels_lo,
	input  logic [4*gcms_pkg::LANE_W-1:0]        gate_levels_hi,
	input  logic [4*gcms_pkg::LANE_W-1:0]        cv_levels_lo,
	input  logic [4*gcms_pkg::LANE_W-1:0]        cv_levels_hi,
	// Output channel.
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output logic signed [gcms_pkg::CV_W-1:0]     merged_cv,
	output logic                                 gate_out,
	output logic                                 cv_updated
);
	import gcms_pkg::*;

	cfg_t    cfg;
	cmd_t    cmd;
	status_t status;

	// Writes complete in the access phase without wait states.
	assign pready = 1'b1;

	// Register file: hold mode, pick rule and the two trigger levels.
	gcms_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.cfg     (cfg)
	);

	// The controller walks each beat through evaluate, the optional select and
	// divide steps and the output load, waiting there if a result is pending.
	gcms_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.status   (status),
		.in_ready (in_ready),
		.cmd      (cmd)
	);

	// The datapath holds the trigger state, applies the merge rule and keeps
	// the output register.
	gcms_datapath #(
		.PORTS     (PORTS),
		.VOLT_BITS (VOLT_BITS)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.cfg            (cfg),
		.action         (action),
		.clock_level    (clock_level),
		.clock_present  (clock_present),
		.gate_levels_lo (gate_levels_lo),
		.gate_levels_hi (gate_levels_hi),
		.cv_levels_lo   (cv_levels_lo),
		.cv_levels_hi   (cv_levels_hi),
		.out_ready      (out_ready),
		.status         (status),
		.out_valid      (out_valid),
		.merged_cv      (merged_cv),
		.gate_out       (gate_out),
		.cv_updated     (cv_updated)
	);

endmodule

FILE: design/gcms_regs.sv
// ----------------------------------------------------------------------------
// Gated CV merge selector configuration registers
// APB-style register file holding hold mode, pick rule and trigger levels.
// ----------------------------------------------------------------------------
module gcms_regs (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [gcms_pkg::ADDR_W-1:0]  paddr,
	input  logic [gcms_pkg::DATA_W-1:0]  pwdata,
	output logic [gcms_pkg::DATA_W-1:0]  prdata,
	output gcms_pkg::cfg_t               cfg
);
	import gcms_pkg::*;

	cfg_t     cfg_q;
	reg_idx_t idx;
	logic     wr_en;

	assign idx   = reg_idx_t'(paddr[ADDR_W-1:2]);
	assign wr_en = psel & penable & pwrite;
	assign cfg   = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.hold_mode    <= 1'b0;
			cfg_q.pick_rule    <= RULE_FIRST;
			cfg_q.trigger_low  <= TRIG_LOW_RST;
			cfg_q.trigger_high <= TRIG_HIGH_RST;
		end else if (wr_en) begin
			case (idx)
				REG_HOLD_MODE: cfg_q.hold_mode    <= pwdata[0];
				REG_PICK_RULE: cfg_q.pick_rule    <= pwdata[RULE_W-1:0];
				REG_TRIG_LOW:  cfg_q.trigger_low  <= pwdata[LANE_W-1:0];
				REG_TRIG_HIGH: cfg_q.trigger_high <= pwdata[LANE_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (idx)
			REG_HOLD_MODE: prdata = DATA_W'(cfg_q.hold_mode);
			REG_PICK_RULE: prdata = DATA_W'(cfg_q.pick_rule);
			REG_TRIG_LOW:  prdata = DATA_W'(cfg_q.trigger_low);
			REG_TRIG_HIGH: prdata = DATA_W'(cfg_q.trigger_high);
			default:       prdata = '0;
		endcase
	end

endmodule

FILE: design/gcms_ctrl.sv
// ----------------------------------------------------------------------------
// Gated CV merge selector controller
// Sequences one beat through evaluate, select, divide and output steps.
// ----------------------------------------------------------------------------
module gcms_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  gcms_pkg::status_t status,
	output logic              in_ready,
	output gcms_pkg::cmd_t    cmd
);
	import gcms_pkg::*;

	state_t state_q;
	state_t state_n;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_n;
		end
	end

	always_comb begin
		state_n = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) state_n = ST_EVAL;
			end
			ST_EVAL: begin
				if (!status.bypass && status.do_pick) state_n = ST_SELECT;
				else state_n = ST_FINISH;
			end
			ST_SELECT: begin
				if (status.need_div) state_n = ST_DIV_MUL;
				else state_n = ST_FINISH;
			end
			ST_DIV_MUL: state_n = ST_DIV_FIN;
			ST_DIV_FIN: state_n = ST_FINISH;
			ST_FINISH: begin
				if (status.out_free) state_n = ST_IDLE;
			end
			default: state_n = ST_IDLE;
		endcase
	end

	always_comb begin
		in_ready     = (state_q == ST_IDLE);
		cmd.load_in  = (state_q == ST_IDLE) && in_valid;
		cmd.eval     = (state_q == ST_EVAL);
		cmd.select   = (state_q == ST_SELECT);
		cmd.div_mul  = (state_q == ST_DIV_MUL);
		cmd.div_fin  = (state_q == ST_DIV_FIN);
		cmd.out_load = (state_q == ST_FINISH) && status.out_free;
	end

endmodule

FILE: design/gcms_datapath.sv
// ----------------------------------------------------------------------------
// Gated CV merge selector datapath
// Input capture, hysteresis triggers, merge rules, reciprocal divide and the
// output register.
// ----------------------------------------------------------------------------
module gcms_datapath #(
	parameter int PORTS     = 8,
	parameter int VOLT_BITS = 16
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  gcms_pkg::cmd_t                       cmd,
	input  gcms_pkg::cfg_t                       cfg,
	input  logic                                 action,
	input  logic signed [gcms_pkg::LANE_W-1:0]   clock_level,
	input  logic                                 clock_present,
	input  logic [4*gcms_pkg::LANE_W-1:0]        gate_levels_lo,
	input  logic [4*gcms_pkg::LANE_W-1:0]        gate_levels_hi,
	input  logic [4*gcms_pkg::LANE_W-1:0]        cv_levels_lo,
	input  logic [4*gcms_pkg::LANE_W-1:0]        cv_levels_hi,
	input  logic                                 out_ready,
	output gcms_pkg::status_t                    status,
	output logic                                 out_valid,
	output logic signed [gcms_pkg::CV_W-1:0]     merged_cv,
	output logic                                 gate_out,
	output logic                                 cv_updated
);
	import gcms_pkg::*;

	localparam int CNT_W = $clog2(PORTS + 1);

	// Captured beat.
	logic                        action_q;
	logic signed [LANE_W-1:0]    clock_level_q;
	logic                        clock_present_q;
	logic signed [VOLT_BITS-1:0] gate_lane_q [PORTS];
	logic signed [VOLT_BITS-1:0] cv_lane_q [PORTS];

	// Block state.
	logic [PORTS-1:0]            armed_q;
	logic                        clock_armed_q;
	logic                        gate_held_q;
	logic [CNT_W-1:0]            count_q;
	choice_t                     last_choice_q;
	logic signed [CV_W-1:0]      held_cv_q;
	logic                        gate_reg_q;
	logic                        updated_q;

	// Divide path.
	logic signed [CV_W-1:0]      sel_q;
	logic [PROD_W-1:0]           prod_q;
	logic                        neg_q;

	// Output register.
	logic                        out_valid_q;
	logic signed [CV_W-1:0]      merged_q;
	logic                        gate_out_q;
	logic                        upd_out_q;

	logic [8*LANE_W-1:0]         gate_all;
	logic [8*LANE_W-1:0]         cv_all;
	logic signed [LANE_W-1:0]    trig_lo;
	logic signed [LANE_W-1:0]    trig_hi;

	logic                        clk_arm_n;
	logic                        clk_edge;
	logic                        sample;
	logic [PORTS-1:0]            armed_n;
	logic [CNT_W-1:0]            count_n;
	logic                        any_n;
	logic                        gate_n;
	logic                        do_pick;

	logic signed [CV_W-1:0]      sum_v;
	logic signed [CV_W-1:0]      first_v;
	logic signed [CV_W-1:0]      last_v;
	logic signed [CV_W-1:0]      min_v;
	logic signed [CV_W-1:0]      max_v;
	logic signed [CV_W-1:0]      replay_v;
	choice_t                     first_idx;
	choice_t                     last_idx;
	choice_t                     min_idx;
	choice_t                     max_idx;
	logic                        any_armed;
	logic signed [CV_W-1:0]      sel_val;
	choice_t                     choice_n;
	logic                        need_div;

	logic [CV_W-1:0]             mag;
	logic [RECIP_W-1:0]          recip;
	logic [PROD_W-1:0]           prod_c;
	logic [CV_W-1:0]             quot;

	assign gate_all = {gate_levels_hi, gate_levels_lo};
	assign cv_all   = {cv_levels_hi, cv_levels_lo};
	assign trig_lo  = cfg.trigger_low;
	assign trig_hi  = cfg.trigger_high;

	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			action_q        <= action;
			clock_level_q   <= clock_level;
			clock_present_q <= clock_present;
			for (int k = 0; k < PORTS; k++) begin
				gate_lane_q[k] <= gate_all[LANE_W*k +: VOLT_BITS];
				cv_lane_q[k]   <= cv_all[LANE_W*k +: VOLT_BITS];
			end
		end
	end

	// Clock trigger: arming from the disarmed state is the edge.
	always_comb begin
		clk_arm_n = clock_armed_q;
		clk_edge  = 1'b0;
		if (clock_armed_q) begin
			if (clock_level_q <= trig_lo) clk_arm_n = 1'b0;
		end else if (clock_level_q >= trig_hi) begin
			clk_arm_n = 1'b1;
			clk_edge  = 1'b1;
		end
	end

	assign sample = clk_edge | ~clock_present_q;

	always_comb begin
		armed_n = armed_q;
		count_n = '0;
		for (int i = 0; i < PORTS; i++) begin
			if (armed_q[i]) begin
				if (LANE_W'(gate_lane_q[i]) <= trig_lo) armed_n[i] = 1'b0;
			end else if (LANE_W'(gate_lane_q[i]) >= trig_hi) begin
				armed_n[i] = 1'b1;
			end
			count_n = count_n + CNT_W'(armed_n[i]);
		end
	end

	assign any_n   = |armed_n;
	assign gate_n  = sample ? any_n : gate_held_q;
	assign do_pick = gate_n & (cfg.hold_mode | (gate_n != gate_held_q));

	// Merge rules over the armed ports; ties keep the lowest port.
	always_comb begin
		sum_v     = '0;
		first_v   = '0;
		last_v    = '0;
		min_v     = '0;
		max_v     = '0;
		replay_v  = '0;
		first_idx = last_choice_q;
		last_idx  = last_choice_q;
		min_idx   = last_choice_q;
		max_idx   = last_choice_q;
		any_armed = 1'b0;
		for (int i = 0; i < PORTS; i++) begin
			if (CHOICE_W'(i) == last_choice_q) replay_v = CV_W'(cv_lane_q[i]);
			if (armed_q[i]) begin
				sum_v = sum_v + CV_W'(cv_lane_q[i]);
				if (!any_armed) begin
					first_v   = CV_W'(cv_lane_q[i]);
					first_idx = CHOICE_W'(i);
				end
				last_v   = CV_W'(cv_lane_q[i]);
				last_idx = CHOICE_W'(i);
				if (!any_armed || CV_W'(cv_lane_q[i]) < min_v) begin
					min_v   = CV_W'(cv_lane_q[i]);
					min_idx = CHOICE_W'(i);
				end
				if (!any_armed || CV_W'(cv_lane_q[i]) > max_v) begin
					max_v   = CV_W'(cv_lane_q[i]);
					max_idx = CHOICE_W'(i);
				end
				any_armed = 1'b1;
			end
		end
	end

	always_comb begin
		sel_val  = sum_v;
		choice_n = last_choice_q;
		need_div = 1'b0;
		case (cfg.pick_rule)
			RULE_FIRST: begin
				sel_val  = first_v;
				choice_n = first_idx;
			end
			RULE_LAST: begin
				sel_val  = last_v;
				choice_n = last_idx;
			end
			RULE_MIN: begin
				sel_val  = min_v;
				choice_n = min_idx;
			end
			RULE_MAX: begin
				sel_val  = max_v;
				choice_n = max_idx;
			end
			RULE_AVG: begin
				choice_n = CHOICE_AVG;
				need_div = 1'b1;
			end
			RULE_SUM: begin
				choice_n = CHOICE_SUM;
			end
			RULE_PREV: begin
				if (last_choice_q < CHOICE_AVG) sel_val = replay_v;
				else if (last_choice_q == CHOICE_AVG) need_div = 1'b1;
			end
			default: ;
		endcase
	end

	// Divide by count as a multiply by a rounded-up reciprocal.
	assign mag    = sel_q[CV_W-1] ? CV_W'(-sel_q) : sel_q;
	assign recip  = RECIP_TABLE[RECIP_IDX_W'(count_q)];
	assign prod_c = mag * recip;
	assign quot   = prod_q[RECIP_SHIFT +: CV_W];

	always_ff @(posedge clk) begin
		if (cmd.select) sel_q <= sel_val;
		if (cmd.div_mul) begin
			prod_q <= prod_c;
			neg_q  <= sel_q[CV_W-1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			armed_q       <= '0;
			clock_armed_q <= 1'b0;
			gate_held_q   <= 1'b0;
			count_q       <= '0;
			last_choice_q <= '0;
			held_cv_q     <= '0;
			gate_reg_q    <= 1'b0;
			updated_q     <= 1'b0;
		end else begin
			if (cmd.eval) begin
				if (action_q) begin
					armed_q     <= '0;
					gate_held_q <= 1'b0;
					updated_q   <= 1'b0;
				end else begin
					clock_armed_q <= clk_arm_n;
					gate_held_q   <= gate_n;
					updated_q     <= do_pick;
					if (sample) begin
						armed_q    <= armed_n;
						count_q    <= count_n;
						gate_reg_q <= any_n;
					end
				end
			end
			if (cmd.select) begin
				last_choice_q <= choice_n;
				if (!need_div) held_cv_q <= sel_val;
			end
			if (cmd.div_fin) begin
				held_cv_q <= neg_q ? CV_W'(-quot) : CV_W'(quot);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			merged_q   <= held_cv_q;
			gate_out_q <= gate_reg_q;
			upd_out_q  <= updated_q;
		end
	end

	assign status.bypass   = action_q;
	assign status.do_pick  = do_pick;
	assign status.need_div = need_div;
	assign status.out_free = ~out_valid_q | out_ready;

	assign out_valid  = out_valid_q;
	assign merged_cv  = merged_q;
	assign gate_out   = gate_out_q;
	assign cv_updated = upd_out_q;

endmodule

FILE: design/gcms_checker.sv
// ----------------------------------------------------------------------------
// Gated CV merge selector checker
// Port-level properties of the merge selector, bound to the top level.
// ----------------------------------------------------------------------------
module gcms_checker (
	input logic                             clk,
	input logic                             arst_n,
	input logic                             in_valid,
	input logic                             in_ready,
	input logic                             out_valid,
	input logic                             out_ready,
	input logic signed [gcms_pkg::CV_W-1:0] merged_cv,
	input logic                             gate_out,
	input logic                             cv_updated
);
	import gcms_pkg::*;

	// A result that waits keeps its fields.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(merged_cv)
			&& $stable(gate_out) && $stable(cv_updated))
		else $error("output beat changed while stalled");

	// The block works on one beat at a time.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("second beat accepted while busy");

	// The CV is only recomputed while the gate output is high.
	a_update_gated: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && cv_updated |-> gate_out)
		else $error("CV update reported with gate low");

endmodule

bind gated_cv_merge_selector gcms_checker u_gcms_checker (.*);
